@@ sv/phb_pkg.sv @@
// ----------------------------------------------------------------------------
// phb_pkg
// Types and constants shared by the Potts heat-bath site update block.
// ----------------------------------------------------------------------------
package phb_pkg;

    localparam int SIDE_LENGTH_DEF = 64;
    localparam int SPIN_STATES_DEF = 4;
    localparam int MATCH_SLOTS     = 5;
    localparam int COORD_W         = 6;
    localparam int SPIN_W          = 2;
    localparam int FRAC_W          = 16;
    localparam int WEIGHT_W        = 16;
    localparam int COUNT_W         = 3;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_LOAD   = 2'd2;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  column;
        logic [FRAC_W-1:0]   rand_fraction;
        logic [SPIN_W-1:0]   spin_first;
        logic [SPIN_W-1:0]   spin_second;
        logic [COUNT_W-1:0]  match_count;
        logic [WEIGHT_W-1:0] weight_value;
    } t_req;

    typedef struct packed {
        logic [SPIN_W-1:0] new_first;
        logic [SPIN_W-1:0] new_second;
        logic              status;
    } t_rsp;

endpackage

@@ sv/potts_heat_bath_site_update.sv @@
// ----------------------------------------------------------------------------
// potts_heat_bath_site_update
// Heat-bath Monte Carlo site update on two Potts lattices held in memory.
// ----------------------------------------------------------------------------
// One item at a time. The input stalls while an item is in progress and while
// its result waits in the output register. A write or a weight load presents
// its result the cycle after accept. An edge column update reads only the
// site itself, in states S_EDGE then S_EDGE_RD, before it presents its result.
// An inner update:
//   - reads the four neighbours through the single read port of the lattice
//     memory, one per cycle (both lattices share one entry word);
//   - fetches the weights for each spin value from the weight memory, one
//     spin value per cycle;
//   - forms the totals one spin value a cycle, then the product with r;
//   - walks the cumulative sums one spin value a cycle.
// It presents its result once both lattices have found their spin value, so
// an early find in both ends the walk sooner. The next item can be accepted
// once the result has been taken and the output register is empty. The
// single lattice read port and the sequential walks over the spin values set
// the length of an inner update.
module potts_heat_bath_site_update
    import phb_pkg::*;
#(
    parameter int SIDE_LENGTH = SIDE_LENGTH_DEF,
    parameter int SPIN_STATES = SPIN_STATES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_data
);

    localparam int CW   = (SIDE_LENGTH > 1) ? $clog2(SIDE_LENGTH) : 1;
    localparam int SITES = SIDE_LENGTH * SIDE_LENGTH;
    localparam int AW   = $clog2(SITES);
    localparam int WDEP = SIDE_LENGTH * MATCH_SLOTS;
    localparam int WAW  = $clog2(WDEP);
    localparam int QW   = $clog2(SPIN_STATES + 1);
    localparam int SUMW = WEIGHT_W + QW;
    localparam int NW   = 3;

    typedef enum logic [3:0] {
        S_IDLE, S_NBR, S_NBR_LAST, S_WREQ, S_WCOL, S_SCAN, S_EDGE, S_EDGE_RD, S_OUT
    } t_state;

    // Memories: site word holds first and second spin together.
    logic [2*SPIN_W-1:0] lat_mem [SITES];
    logic [WEIGHT_W-1:0] wt_mem  [WDEP];

    t_state              r_state;
    logic [CW-1:0]       r_row, r_col;
    logic [FRAC_W-1:0]   r_frac;
    logic [2:0]          r_nidx;
    logic [2*SPIN_W-1:0] r_nb [4];
    logic [QW-1:0]       r_q;
    logic [WEIGHT_W-1:0] r_w1 [SPIN_STATES];
    logic [WEIGHT_W-1:0] r_w2 [SPIN_STATES];
    logic [SUMW-1:0]     r_tot1, r_tot2, r_cum1, r_cum2;
    logic [SPIN_W-1:0]   r_pick1, r_pick2;
    logic                r_got1, r_got2;
    logic                r_wvalid;
    logic [QW-1:0]       r_wq;
    logic [FRAC_W+SUMW-1:0] r_lim1, r_lim2;

    logic [AW-1:0]       rd_addr;
    logic [2*SPIN_W-1:0] r_rd;
    logic [WAW-1:0]      w_addr1, w_addr2;
    logic [WEIGHT_W-1:0] r_wrd1, r_wrd2;
    logic                r_ovalid;
    t_rsp                r_odata;

    // Reduce a coordinate modulo the side through a constant table.
    function automatic logic [CW-1:0] wrap_c(input logic [COORD_W-1:0] v);
        logic [CW-1:0] res;
        res = '0;
        for (int k = 0; k < (1 << COORD_W); k++) begin
            if (v == COORD_W'(k)) begin
                res = CW'(k % SIDE_LENGTH);
            end
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] site(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(32'(r) * SIDE_LENGTH + 32'(c));
    endfunction

    // Count neighbours matching spin value q in one lattice half.
    function automatic logic [NW-1:0] cnt(input logic [QW-1:0] q, input logic hi,
                                          input logic [2*SPIN_W-1:0] n0,
                                          input logic [2*SPIN_W-1:0] n1,
                                          input logic [2*SPIN_W-1:0] n2,
                                          input logic [2*SPIN_W-1:0] n3);
        logic [NW-1:0] s;
        logic [SPIN_W-1:0] v0, v1, v2, v3;
        v0 = hi ? n0[2*SPIN_W-1:SPIN_W] : n0[SPIN_W-1:0];
        v1 = hi ? n1[2*SPIN_W-1:SPIN_W] : n1[SPIN_W-1:0];
        v2 = hi ? n2[2*SPIN_W-1:SPIN_W] : n2[SPIN_W-1:0];
        v3 = hi ? n3[2*SPIN_W-1:SPIN_W] : n3[SPIN_W-1:0];
        s = NW'(QW'(v0) == q) + NW'(QW'(v1) == q) + NW'(QW'(v2) == q)
          + NW'(QW'(v3) == q);
        return s;
    endfunction

    logic [CW-1:0] up_r, dn_r;
    assign up_r = (32'(r_row) == SIDE_LENGTH - 1) ? '0 : CW'(r_row + CW'(1));
    assign dn_r = (r_row == '0) ? CW'(SIDE_LENGTH - 1) : CW'(r_row - CW'(1));

    // Neighbour read address, in order left, right, up, down; the site itself in S_EDGE.
    always_comb begin
        unique case (r_nidx[1:0])
            2'd0:    rd_addr = site(r_row, CW'(r_col - CW'(1)));
            2'd1:    rd_addr = site(r_row, CW'(r_col + CW'(1)));
            2'd2:    rd_addr = site(up_r, r_col);
            default: rd_addr = site(dn_r, r_col);
        endcase
        if (r_state == S_EDGE) begin
            rd_addr = site(r_row, r_col);
        end
    end

    logic [NW-1:0] n1c, n2c;
    assign n1c = cnt(r_q, 1'b0, r_nb[0], r_nb[1], r_nb[2], r_nb[3]);
    assign n2c = cnt(r_q, 1'b1, r_nb[0], r_nb[1], r_nb[2], r_nb[3]);
    assign w_addr1 = WAW'(32'(r_col) * MATCH_SLOTS + 32'(n1c));
    assign w_addr2 = WAW'(32'(r_col) * MATCH_SLOTS + 32'(n2c));

    logic [SUMW-1:0]  cum1_n, cum2_n;
    logic [SPIN_W-1:0] qs;
    assign cum1_n = r_cum1 + SUMW'(r_w1[r_q[$clog2(SPIN_STATES)-1:0]]);
    assign cum2_n = r_cum2 + SUMW'(r_w2[r_q[$clog2(SPIN_STATES)-1:0]]);
    assign qs     = SPIN_W'(r_q);

    logic in_acc, out_acc;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;
    assign o_stall = (r_state != S_IDLE) || r_ovalid;

    // Weight memory: read two entries, write on a load.
    always_ff @(posedge i_clk) begin
        r_wrd1 <= wt_mem[w_addr1];
        r_wrd2 <= wt_mem[w_addr2];
        if (in_acc && i_data.req_type == REQ_LOAD && i_data.match_count < COUNT_W'(MATCH_SLOTS)) begin
            wt_mem[WAW'(32'(wrap_c(i_data.column)) * MATCH_SLOTS
                       + 32'(i_data.match_count))] <= i_data.weight_value;
        end
    end

    // Lattice memory: one read port, one write port.
    always_ff @(posedge i_clk) begin
        r_rd <= lat_mem[rd_addr];
        if (in_acc && i_data.req_type == REQ_WRITE) begin
            lat_mem[site(wrap_c(i_data.row), wrap_c(i_data.column))]
                <= {i_data.spin_second, i_data.spin_first};
        end else if (r_state == S_SCAN && r_got1 && r_got2) begin
            lat_mem[site(r_row, r_col)] <= {r_pick2, r_pick1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_wvalid <= 1'b0;
        end else begin
            if (out_acc) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_row  <= wrap_c(i_data.row);
                        r_col  <= wrap_c(i_data.column);
                        r_frac <= i_data.rand_fraction;
                        r_nidx <= '0;
                        if (i_data.req_type == REQ_UPDATE) begin
                            if (wrap_c(i_data.column) == '0 ||
                                32'(wrap_c(i_data.column)) == SIDE_LENGTH - 1) begin
                                r_state <= S_EDGE;
                            end else begin
                                r_state <= S_NBR;
                            end
                        end else begin
                            r_odata.status <= STATUS_DONE;
                            if (i_data.req_type == REQ_WRITE) begin
                                r_odata.new_first  <= i_data.spin_first;
                                r_odata.new_second <= i_data.spin_second;
                            end else begin
                                r_odata.new_first  <= '0;
                                r_odata.new_second <= '0;
                            end
                            r_ovalid <= 1'b1;
                        end
                    end
                end
                S_EDGE: begin
                    r_state <= S_EDGE_RD;
                end
                S_EDGE_RD: begin
                    r_odata.new_first  <= r_rd[SPIN_W-1:0];
                    r_odata.new_second <= r_rd[2*SPIN_W-1:SPIN_W];
                    r_odata.status     <= STATUS_REFUSED;
                    r_ovalid           <= 1'b1;
                    r_state            <= S_IDLE;
                end
                S_NBR: begin
                    // Issue a read per cycle; capture the previous one.
                    if (r_nidx != '0) begin
                        r_nb[r_nidx[1:0] - 2'd1] <= r_rd;
                    end
                    if (r_nidx == 3'd3) begin
                        r_state <= S_NBR_LAST;
                    end
                    r_nidx <= r_nidx + 3'd1;
                end
                S_NBR_LAST: begin
                    r_nb[3]  <= r_rd;
                    r_q      <= '0;
                    r_wvalid <= 1'b0;
                    r_state  <= S_WREQ;
                end
                S_WREQ: begin
                    // Address for value r_q is live now; data lands next cycle.
                    r_wvalid <= 1'b1;
                    r_wq     <= r_q;
                    if (r_wvalid) begin
                        r_w1[r_wq[$clog2(SPIN_STATES)-1:0]] <= r_wrd1;
                        r_w2[r_wq[$clog2(SPIN_STATES)-1:0]] <= r_wrd2;
                    end
                    if (32'(r_q) == SPIN_STATES - 1) begin
                        r_state <= S_WCOL;
                    end else begin
                        r_q <= r_q + QW'(1);
                    end
                end
                S_WCOL: begin
                    r_w1[r_q[$clog2(SPIN_STATES)-1:0]] <= r_wrd1;
                    r_w2[r_q[$clog2(SPIN_STATES)-1:0]] <= r_wrd2;
                    r_q     <= '0;
                    r_cum1  <= '0;
                    r_cum2  <= '0;
                    r_got1  <= 1'b0;
                    r_got2  <= 1'b0;
                    r_nidx  <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Clear the totals, sum one spin value a cycle, then the products.
                    if (r_nidx == '0) begin
                        r_tot1 <= '0;
                        r_tot2 <= '0;
                        r_nidx <= 3'd1;
                        r_q    <= '0;
                    end else if (r_nidx == 3'd1) begin
                        r_tot1 <= r_tot1 + SUMW'(r_w1[r_q[$clog2(SPIN_STATES)-1:0]]);
                        r_tot2 <= r_tot2 + SUMW'(r_w2[r_q[$clog2(SPIN_STATES)-1:0]]);
                        if (32'(r_q) == SPIN_STATES - 1) begin
                            r_nidx <= 3'd2;
                        end else begin
                            r_q <= r_q + QW'(1);
                        end
                    end else begin
                        r_lim1  <= (FRAC_W+SUMW)'(r_tot1) * (FRAC_W+SUMW)'(r_frac);
                        r_lim2  <= (FRAC_W+SUMW)'(r_tot2) * (FRAC_W+SUMW)'(r_frac);
                        r_q     <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Advance one spin value; lock the first that clears r*total.
                    if (!r_got1) begin
                        r_cum1 <= cum1_n;
                        if ({cum1_n, 16'd0} >= (FRAC_W+SUMW)'(r_lim1) ||
                            32'(r_q) == SPIN_STATES - 1) begin
                            r_got1  <= 1'b1;
                            r_pick1 <= qs;
                        end
                    end
                    if (!r_got2) begin
                        r_cum2 <= cum2_n;
                        if ({cum2_n, 16'd0} >= (FRAC_W+SUMW)'(r_lim2) ||
                            32'(r_q) == SPIN_STATES - 1) begin
                            r_got2  <= 1'b1;
                            r_pick2 <= qs;
                        end
                    end
                    if (32'(r_q) != SPIN_STATES - 1) begin
                        r_q <= r_q + QW'(1);
                    end
                    if (r_got1 && r_got2) begin
                        r_odata.new_first  <= r_pick1;
                        r_odata.new_second <= r_pick2;
                        r_odata.status     <= STATUS_DONE;
                        r_ovalid           <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

@@ verif/tb_potts_heat_bath_site_update.sv @@
// ----------------------------------------------------------------------------
// tb_potts_heat_bath_site_update
// Self-checking bench: drives writes, weight loads and heat-bath updates,
// predicts every result from its own copy of the lattices and weights.
// ----------------------------------------------------------------------------
module tb_potts_heat_bath_site_update
    import phb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE  = SIDE_LENGTH_DEF;
    localparam int SPINS = SPIN_STATES_DEF;
    localparam int REQ_BITS = $bits(t_req);
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Scoreboard: holds the predicted lattices and weight table, and the
    // queue of responses still owed by the block.
    class site_scoreboard;
        logic [1:0]  lat_a [SIDE*SIDE];
        logic [1:0]  lat_b [SIDE*SIDE];
        logic [15:0] weights [SIDE*MATCH_SLOTS];
        t_rsp        owed [$];
        int          mismatches;

        function new();
            mismatches = 0;
            foreach (lat_a[i]) begin
                lat_a[i] = '0;
                lat_b[i] = '0;
            end
            foreach (weights[i]) weights[i] = '0;
        endfunction

        function logic [1:0] choose(bit use_b, int r, int c, logic [15:0] frac);
            int up, dn, n;
            logic [1:0] nb [4];
            logic [63:0] w [SPINS];
            logic [63:0] total, cum;
            up = (r + 1 == SIDE) ? 0 : r + 1;
            dn = (r == 0) ? SIDE - 1 : r - 1;
            nb[0] = use_b ? lat_b[r*SIDE+c-1] : lat_a[r*SIDE+c-1];
            nb[1] = use_b ? lat_b[r*SIDE+c+1] : lat_a[r*SIDE+c+1];
            nb[2] = use_b ? lat_b[up*SIDE+c]  : lat_a[up*SIDE+c];
            nb[3] = use_b ? lat_b[dn*SIDE+c]  : lat_a[dn*SIDE+c];
            total = '0;
            for (int q = 0; q < SPINS; q++) begin
                n = 0;
                for (int k = 0; k < 4; k++) if (nb[k] == q) n++;
                w[q] = 64'(weights[c*MATCH_SLOTS+n]);
                total += w[q];
            end
            cum = '0;
            for (int q = 0; q < SPINS; q++) begin
                cum += w[q];
                if ((cum << 16) >= 64'(frac) * total) return q[1:0];
            end
            return 2'(SPINS - 1);
        endfunction

        // Note an accepted request: update the model and queue its response.
        function void note_request(t_req rq);
            t_rsp rs;
            int r, c, pos;
            logic [1:0] a, b;
            r = int'(rq.row) % SIDE;
            c = int'(rq.column) % SIDE;
            pos = r*SIDE + c;
            rs = '0;
            case (rq.req_type)
                REQ_WRITE: begin
                    lat_a[pos] = rq.spin_first;
                    lat_b[pos] = rq.spin_second;
                    rs.new_first = rq.spin_first;
                    rs.new_second = rq.spin_second;
                end
                REQ_UPDATE: begin
                    if (c == 0 || c == SIDE - 1) begin
                        rs.new_first = lat_a[pos];
                        rs.new_second = lat_b[pos];
                        rs.status = STATUS_REFUSED;
                    end else begin
                        a = choose(0, r, c, rq.rand_fraction);
                        b = choose(1, r, c, rq.rand_fraction);
                        lat_a[pos] = a;
                        lat_b[pos] = b;
                        rs.new_first = a;
                        rs.new_second = b;
                        rs.status = STATUS_DONE;
                    end
                end
                REQ_LOAD: begin
                    if (rq.match_count < MATCH_SLOTS)
                        weights[c*MATCH_SLOTS+rq.match_count] = rq.weight_value;
                end
                default: ;
            endcase
            owed.push_back(rs);
        endfunction

        // Compare one accepted response against the oldest prediction.
        function void check_response(t_rsp got);
            t_rsp exp_rs;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %p", got);
                return;
            end
            exp_rs = owed.pop_front();
            if (got.new_first !== exp_rs.new_first || got.new_second !== exp_rs.new_second
                || got.status !== exp_rs.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, actual %p", exp_rs, got);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, i_stall, o_stall, o_valid;
    t_req i_data;
    t_rsp o_data;

    potts_heat_bath_site_update u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    site_scoreboard sb;
    int  send_idle_pct;    // sender gap chance, percent
    int  recv_idle_pct;    // receiver stall chance, percent
    bit  hold_off;         // long receiver hold-off in force
    bit  written [SIDE*SIDE];
    bit  wloaded [SIDE*MATCH_SLOTS];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    // Receiver: stall at random, or hold off entirely during the pressure test.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check every response taken by the receiver.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_response(o_data);
    end

    // Offer one item, with a random gap before it; hold it until accepted.
    task automatic send_item(t_req rq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= rq;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(rq);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic t_req random_bits();
        t_req rq;
        rq = t_req'(REQ_BITS'({$urandom, $urandom}));
        return rq;
    endfunction

    task automatic do_write(int r, int c, logic [1:0] a, logic [1:0] b);
        t_req rq;
        rq = random_bits();
        rq.req_type = REQ_WRITE;
        rq.row = COORD_W'(r); rq.column = COORD_W'(c); rq.spin_first = a; rq.spin_second = b;
        written[r*SIDE+c] = 1'b1;
        send_item(rq);
    endtask

    task automatic do_load(int c, int n, logic [15:0] w);
        t_req rq;
        rq = random_bits();
        rq.req_type = REQ_LOAD;
        rq.column = COORD_W'(c); rq.match_count = COUNT_W'(n); rq.weight_value = w;
        if (n < MATCH_SLOTS) wloaded[c*MATCH_SLOTS+n] = 1'b1;
        send_item(rq);
    endtask

    // Update only where every site and weight read is known to be written.
    function automatic bit update_ready(int r, int c);
        int up, dn;
        if (!written[r*SIDE+c]) return 0;
        if (c == 0 || c == SIDE - 1) return 1;
        up = (r + 1) % SIDE;
        dn = (r + SIDE - 1) % SIDE;
        if (!written[r*SIDE+c-1] || !written[r*SIDE+c+1] ||
            !written[up*SIDE+c] || !written[dn*SIDE+c]) return 0;
        for (int n = 0; n < MATCH_SLOTS; n++) if (!wloaded[c*MATCH_SLOTS+n]) return 0;
        return 1;
    endfunction

    task automatic do_update(int r, int c, logic [15:0] frac);
        t_req rq;
        rq = random_bits();
        rq.req_type = REQ_UPDATE;
        rq.row = COORD_W'(r); rq.column = COORD_W'(c); rq.rand_fraction = frac;
        send_item(rq);
    endtask

    // Write a plus-shaped patch and its weights, then update its centre.
    task automatic patch_and_update(int r, int c, logic [15:0] frac, bit zero_w);
        int up, dn;
        up = (r + 1) % SIDE;
        dn = (r + SIDE - 1) % SIDE;
        do_write(r, c, 2'($urandom), 2'($urandom));
        if (c > 0) do_write(r, c - 1, 2'($urandom), 2'($urandom));
        if (c < SIDE - 1) do_write(r, c + 1, 2'($urandom), 2'($urandom));
        do_write(up, c, 2'($urandom), 2'($urandom));
        do_write(dn, c, 2'($urandom), 2'($urandom));
        for (int n = 0; n < MATCH_SLOTS; n++)
            do_load(c, n, zero_w ? 16'd0 : 16'($urandom));
        do_update(r, c, frac);
    endtask

    task automatic random_phase(int count);
        int r, c, pick;
        t_req rq;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            r = $urandom_range(SIDE - 1);
            c = $urandom_range(SIDE - 1);
            if (pick < 30) begin
                do_write(r, c, 2'($urandom), 2'($urandom));
            end else if (pick < 45) begin
                do_load(c, $urandom_range(7), 16'($urandom));
            end else if (pick < 50) begin
                rq = random_bits();
                rq.req_type = REQ_SPARE;
                send_item(rq);
            end else begin
                // Prefer small rows and inner columns so patches overlap.
                r = $urandom_range(7);
                c = $urandom_range(1, 8);
                if (!update_ready(r, c) || $urandom_range(3) == 0)
                    patch_and_update(r, c, 16'($urandom), $urandom_range(15) == 0);
                else
                    do_update(r, c, 16'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        i_valid = 1'b0;
        i_data = '0;
        i_rst_n = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (written[i]) written[i] = 1'b0;
        foreach (wloaded[i]) wloaded[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of spins and fractions, edge columns, zero
        // weights, over-range load, wrap of the row.
        do_write(0, 0, 2'd3, 2'd0);
        do_update(0, 0, 16'hFFFF);
        do_write(5, SIDE - 1, 2'd0, 2'd3);
        do_update(5, SIDE - 1, 16'h0000);
        patch_and_update(0, 1, 16'h0000, 1'b0);
        patch_and_update(SIDE - 1, SIDE - 2, 16'hFFFF, 1'b0);
        patch_and_update(3, 4, 16'h8000, 1'b1);
        do_load(4, 7, 16'hFFFF);
        do_load(4, 5, 16'h0000);
        do_update(3, 4, 16'hFFFF);

        send_idle_pct = 28; recv_idle_pct = 83;
        random_phase(170);

        // Pressure: receiver holds off while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                random_phase(20);
                drain();
            end
        join

        send_idle_pct = 83; recv_idle_pct = 28;
        random_phase(170);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(170);
        drain();

        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
